>>> rtl/mdp_pkg.sv
// Types, constants and codes shared by the max dot product point store.
package mdp_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COORD_W    = 31;
   localparam int PROD_W     = 2 * COORD_W;
   localparam int ACC_W      = PROD_W + 1;
   localparam int DOT_W      = 62;
   localparam int NUM_LANES  = 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [NUM_LANES-1:0] point_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [ACC_W-1:0]   acc_type;
   typedef logic signed [DOT_W-1:0]   dot_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic [ADDR_W-1:0]         addr_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   localparam dot_type EMPTY_DOT = -62'sd2000000000000000000;
   localparam dot_type DOT_MAX   = {1'b0, {(DOT_W-1){1'b1}}};
   localparam dot_type DOT_MIN   = {1'b1, {(DOT_W-1){1'b0}}};

   // One beat travelling along the multiply-accumulate chain
   typedef struct packed {
      logic      valid;
      point_type pt;
      acc_type   acc;
   } cell_beat_type;

endpackage

>>> rtl/mdp_req_if.sv
// Request channel: operation and coordinates with valid/ready handshake.
interface mdp_req_if;
   logic               valid;
   logic               ready;
   mdp_pkg::op_type    operation;
   mdp_pkg::coord_type x_coord;
   mdp_pkg::coord_type y_coord;

   modport source (output valid, output operation, output x_coord, output y_coord,
                   input ready);
   modport sink   (input valid, input operation, input x_coord, input y_coord,
                   output ready);
endinterface

>>> rtl/mdp_rsp_if.sv
// Response channel: status and maximum dot product with valid/ready handshake.
interface mdp_rsp_if;
   logic                valid;
   logic                ready;
   mdp_pkg::status_type status;
   mdp_pkg::dot_type    max_dot;

   modport source (output valid, output status, output max_dot, input ready);
   modport sink   (input valid, input status, input max_dot, output ready);
endinterface

>>> rtl/mdp_mac_cell.sv
// Multiply-accumulate cell: adds its lane's product to the running sum and hands it on.
module mdp_mac_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  mdp_pkg::coord_type     coeff,
   input  mdp_pkg::cell_beat_type beat_in,
   output mdp_pkg::cell_beat_type beat_out
);
   import mdp_pkg::*;

   cell_beat_type stage_in;
   cell_beat_type stage_ff;
   prod_type      prod_in;
   prod_type      prod_ff;
   cell_beat_type out_in;
   cell_beat_type out_ff;

   // Take lane zero, shift the remaining coordinates down for the next cell
   always_comb begin
      stage_in.valid = beat_in.valid;
      stage_in.acc   = beat_in.acc;
      for (int k = 0; k < NUM_LANES - 1; k++) begin
         stage_in.pt[k] = beat_in.pt[k+1];
      end
      stage_in.pt[NUM_LANES-1] = '0;
      prod_in = prod_type'($signed(beat_in.pt[0])) * prod_type'(coeff);
   end

   always_comb begin
      out_in.valid = stage_ff.valid;
      out_in.pt    = stage_ff.pt;
      out_in.acc   = stage_ff.acc + acc_type'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
         out_ff.valid   <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
         out_ff.valid   <= out_in.valid;
      end
      stage_ff.pt  <= stage_in.pt;
      stage_ff.acc <= stage_in.acc;
      prod_ff      <= prod_in;
      out_ff.pt    <= out_in.pt;
      out_ff.acc   <= out_in.acc;
   end

   assign beat_out = out_ff;

endmodule

>>> rtl/max_dot_product_point_store_top.sv
// Point store with exact maximum dot product query over a chain of MAC cells.
// Insert: the status is loaded in the finish state; the next request is taken back in idle.
// Query: one stored point read per cycle, streamed through the cell chain; the running maximum
//   is loaded as the result after memory reads, the registered read, each cell and the finish state.
// Empty query or refused insert: the result is loaded in the finish state, as for an insert.
// Synchronous reset empties the store; no clearing pass, entries are read only once written.
module max_dot_product_point_store_top (
   input  logic clock,
   input  logic reset,
   mdp_req_if.sink   req_if,
   mdp_rsp_if.source rsp_if
);
   import mdp_pkg::*;

   state_type     state_ff;
   state_type     state_in;

   count_type     count_ff;
   count_type     issue_cnt_ff;
   count_type     done_cnt_ff;
   point_type     q_ff;
   point_type     mem [MAX_POINTS];
   point_type     rd_pt_ff;
   logic          rd_valid_ff;
   acc_type       best_ff;
   logic          first_ff;
   logic          scan_ff;
   status_type    res_status_ff;
   dot_type       res_dot_ff;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   dot_type       rsp_dot_ff;

   logic          req_ready;
   logic          req_fire;
   logic          issue_v;
   logic          load_rsp;
   logic          is_full;
   logic          is_empty;
   logic          last_beat;
   dot_type       sat_best;
   point_type     req_pt;

   cell_beat_type chain [NUM_LANES+1];

   assign is_full   = (count_ff == count_type'(MAX_POINTS));
   assign is_empty  = (count_ff == '0);
   assign req_fire  = req_if.valid && req_ready;
   assign last_beat = chain[NUM_LANES].valid
                      && (count_type'(done_cnt_ff + 1'b1) == count_ff);

   always_comb begin
      req_pt[0] = req_if.x_coord;
      req_pt[1] = req_if.y_coord;
   end

   // Clamp the 63-bit sum into the signed 62-bit result range
   always_comb begin
      if (!best_ff[ACC_W-1] && best_ff[ACC_W-2]) begin
         sat_best = DOT_MAX;
      end else if (best_ff[ACC_W-1] && !best_ff[ACC_W-2]) begin
         sat_best = DOT_MIN;
      end else begin
         sat_best = best_ff[DOT_W-1:0];
      end
   end

   // Control state machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      issue_v   = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               if (req_if.operation == OP_QUERY && !is_empty) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            issue_v = (issue_cnt_ff != count_ff);
            if (last_beat) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Point memory: write on insert, registered read during a scan
   always_ff @(posedge clock) begin
      if (req_fire && req_if.operation == OP_INSERT && !is_full) begin
         mem[count_ff[ADDR_W-1:0]] <= req_pt;
      end
      rd_pt_ff <= mem[issue_cnt_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_cnt_ff <= '0;
         done_cnt_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue_v;
         if (issue_v) begin
            issue_cnt_ff <= count_type'(issue_cnt_ff + 1'b1);
         end
         if (chain[NUM_LANES].valid) begin
            done_cnt_ff <= count_type'(done_cnt_ff + 1'b1);
            first_ff    <= 1'b0;
         end
         if (req_fire) begin
            issue_cnt_ff <= '0;
            done_cnt_ff  <= '0;
            first_ff     <= 1'b1;
            if (req_if.operation == OP_INSERT && !is_full) begin
               count_ff <= count_type'(count_ff + 1'b1);
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Running maximum and result payload
   always_ff @(posedge clock) begin
      if (chain[NUM_LANES].valid && (first_ff || chain[NUM_LANES].acc > best_ff)) begin
         best_ff <= chain[NUM_LANES].acc;
      end
      if (req_fire) begin
         q_ff <= req_pt;
         if (req_if.operation == OP_INSERT) begin
            scan_ff    <= 1'b0;
            res_dot_ff <= '0;
            if (is_full) begin
               res_status_ff <= STATUS_FULL;
            end else begin
               res_status_ff <= STATUS_OK;
            end
         end else if (is_empty) begin
            scan_ff       <= 1'b0;
            res_status_ff <= STATUS_EMPTY;
            res_dot_ff    <= EMPTY_DOT;
         end else begin
            scan_ff       <= 1'b1;
            res_status_ff <= STATUS_OK;
            res_dot_ff    <= '0;
         end
      end
      if (load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_dot_ff    <= scan_ff ? sat_best : res_dot_ff;
      end
   end

   // Chain of multiply-accumulate cells, one per coordinate lane
   always_comb begin
      chain[0].valid = rd_valid_ff;
      chain[0].pt    = rd_pt_ff;
      chain[0].acc   = '0;
   end

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      mdp_mac_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .coeff    (q_ff[g]),
         .beat_in  (chain[g]),
         .beat_out (chain[g+1])
      );
   end

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.max_dot = rsp_dot_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MAX_POINTS))
      else $error("point count beyond capacity");

   a_done_le_issue: assert property (@(posedge clock) disable iff (reset)
      done_cnt_ff <= issue_cnt_ff)
      else $error("more chain results than reads issued");

   a_chain_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[NUM_LANES].valid |-> state_ff == ST_SCAN)
      else $error("chain result outside a scan");

   a_load_from_finish: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid_ff && $past(state_ff) == ST_FINISH)
      else $error("result loaded outside finish");

endmodule
